// ----- rtl/tbo_pkg.sv -----
// shared widths, constants and input field offsets for the triangle/box overlap test
// used by every module of the block; depends on nothing
package tbo_pkg;

    localparam int CB = 32;            // coordinate bits
    localparam int XW = CB + 4;        // differences and sums of coordinates
    localparam int MW = 2 * XW;        // one product of two differences
    localparam int SW = MW + 2;        // sum of two products
    localparam int TW = SW + 22;       // tolerance-scaled terms
    localparam int TOL = 1000000;
    localparam int IN_W = 320;         // packed input request, whole bytes
    localparam int OUT_W = 8;

    localparam int OFS_AX = 0;
    localparam int OFS_AY = CB;
    localparam int OFS_BX = 2 * CB;
    localparam int OFS_BY = 3 * CB;
    localparam int OFS_CX = 4 * CB;
    localparam int OFS_CY = 5 * CB;
    localparam int OFS_X0 = 6 * CB;
    localparam int OFS_Y0 = 7 * CB;
    localparam int OFS_W = 8 * CB;
    localparam int OFS_H = 9 * CB - 1;

    localparam logic signed [TW-1:0] TOL_S = TW'(TOL);
    localparam logic signed [TW-1:0] TOL1_S = TW'(TOL + 1);

    typedef logic signed [XW-1:0] coord_t;

endpackage

// ----- rtl/tbo_corner_lane.sv -----
// barycentric test of one box corner against the triangle, six register stages
// depends on tbo_pkg
module tbo_corner_lane
    import tbo_pkg::*;
(
    input  logic   clk,
    input  logic   en,
    input  coord_t ax,
    input  coord_t ay,
    input  coord_t bx,
    input  coord_t by,
    input  coord_t cx,
    input  coord_t cy,
    input  coord_t px,
    input  coord_t py,
    output logic   corner_in
);

    coord_t v0x_reg, v0y_reg, v1x_reg, v1y_reg, v2x_reg, v2y_reg;
    coord_t v0x_next, v0y_next, v1x_next, v1y_next, v2x_next, v2y_next;
    logic signed [MW-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [MW-1:0] p0_next, p1_next, p2_next, p3_next, p4_next, p5_next;
    logic signed [SW-1:0] d_reg, nu_reg, nv_reg, d_next, nu_next, nv_next;
    logic signed [TW-1:0] tn_reg, tv_reg, td_reg, dw_reg;
    logic signed [TW-1:0] tn_next, tv_next, td_next, dw_next;
    logic                 dpos4_reg, dnz4_reg, dpos4_next, dnz4_next;
    logic signed [TW-1:0] s1_reg, s2_reg, s3_reg, td5_reg;
    logic signed [TW-1:0] s1_next, s2_next, s3_next, td5_next;
    logic                 dpos5_reg, dnz5_reg;
    logic                 flag_reg, flag_next;

    always_comb
    begin
        v0x_next = cx - ax;
        v0y_next = cy - ay;
        v1x_next = bx - ax;
        v1y_next = by - ay;
        v2x_next = px - ax;
        v2y_next = py - ay;

        p0_next = MW'(v0x_reg) * MW'(v1y_reg);
        p1_next = MW'(v0y_reg) * MW'(v1x_reg);
        p2_next = MW'(v2x_reg) * MW'(v1y_reg);
        p3_next = MW'(v2y_reg) * MW'(v1x_reg);
        p4_next = MW'(v0x_reg) * MW'(v2y_reg);
        p5_next = MW'(v0y_reg) * MW'(v2x_reg);

        d_next  = SW'(p0_reg) - SW'(p1_reg);
        nu_next = SW'(p2_reg) - SW'(p3_reg);
        nv_next = SW'(p4_reg) - SW'(p5_reg);

        // tolerance terms scaled by the denominator
        tn_next    = TW'(nu_reg) * TOL_S;
        tv_next    = TW'(nv_reg) * TOL_S;
        td_next    = TW'(d_reg) * TOL1_S;
        dw_next    = TW'(d_reg);
        dpos4_next = (d_reg > 0);
        dnz4_next  = (d_reg != 0);

        s1_next  = tn_reg + dw_reg;
        s2_next  = tv_reg + dw_reg;
        s3_next  = tn_reg + tv_reg;
        td5_next = td_reg;

        // negative denominator flips every comparison
        if (dpos5_reg)
        begin
            flag_next = dnz5_reg && (s1_reg >= 0) && (s2_reg >= 0) && (s3_reg <= td5_reg);
        end
        else
        begin
            flag_next = dnz5_reg && (s1_reg <= 0) && (s2_reg <= 0) && (s3_reg >= td5_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v0x_reg   <= v0x_next;
            v0y_reg   <= v0y_next;
            v1x_reg   <= v1x_next;
            v1y_reg   <= v1y_next;
            v2x_reg   <= v2x_next;
            v2y_reg   <= v2y_next;
            p0_reg    <= p0_next;
            p1_reg    <= p1_next;
            p2_reg    <= p2_next;
            p3_reg    <= p3_next;
            p4_reg    <= p4_next;
            p5_reg    <= p5_next;
            d_reg     <= d_next;
            nu_reg    <= nu_next;
            nv_reg    <= nv_next;
            tn_reg    <= tn_next;
            tv_reg    <= tv_next;
            td_reg    <= td_next;
            dw_reg    <= dw_next;
            dpos4_reg <= dpos4_next;
            dnz4_reg  <= dnz4_next;
            s1_reg    <= s1_next;
            s2_reg    <= s2_next;
            s3_reg    <= s3_next;
            td5_reg   <= td5_next;
            dpos5_reg <= dpos4_reg;
            dnz5_reg  <= dnz4_reg;
            flag_reg  <= flag_next;
        end
    end

    assign corner_in = flag_reg;

endmodule

// ----- rtl/tbo_edge_lane.sv -----
// strict crossing of one triangle edge with one box side, six register stages
// depends on tbo_pkg
module tbo_edge_lane
    import tbo_pkg::*;
(
    input  logic   clk,
    input  logic   en,
    input  coord_t pa,
    input  coord_t qa,
    input  coord_t pb,
    input  coord_t qb,
    input  coord_t line,
    input  coord_t lo,
    input  coord_t span,
    output logic   hit
);

    coord_t dd_reg, qal_reg, lpa_reg, qba_reg, span1_reg;
    coord_t dd_next, qal_next, lpa_next, qba_next;
    logic   cross1_reg, cross1_next;
    logic signed [MW-1:0] m1_reg, m2_reg, m1_next, m2_next;
    coord_t ad_reg, ad_next, span2_reg;
    logic   neg2_reg, neg2_next, cross2_reg;
    logic signed [SW-1:0] num_reg, num_next;
    logic signed [MW-1:0] sd_reg, sd_next, sd4_reg;
    logic   neg3_reg, cross3_reg, cross4_reg;
    logic signed [SW-1:0] numa_reg, numa_next;
    logic   flag_reg, flag_next, flag6_reg;

    always_comb
    begin
        dd_next     = pb - pa;
        qal_next    = qa - lo;
        lpa_next    = line - pa;
        qba_next    = qb - qa;
        // endpoints strictly on opposite sides of the line
        cross1_next = ((pa < line) && (pb > line)) || ((pa > line) && (pb < line));

        m1_next  = MW'(qal_reg) * MW'(dd_reg);
        m2_next  = MW'(lpa_reg) * MW'(qba_reg);
        neg2_next = dd_reg[XW-1];
        ad_next  = dd_reg[XW-1] ? -dd_reg : dd_reg;

        num_next = SW'(m1_reg) + SW'(m2_reg);
        sd_next  = MW'(span2_reg) * MW'(ad_reg);

        numa_next = neg3_reg ? -num_reg : num_reg;

        flag_next = cross4_reg && (numa_reg > 0) && (numa_reg < SW'(sd4_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dd_reg     <= dd_next;
            qal_reg    <= qal_next;
            lpa_reg    <= lpa_next;
            qba_reg    <= qba_next;
            span1_reg  <= span;
            cross1_reg <= cross1_next;
            m1_reg     <= m1_next;
            m2_reg     <= m2_next;
            ad_reg     <= ad_next;
            neg2_reg   <= neg2_next;
            span2_reg  <= span1_reg;
            cross2_reg <= cross1_reg;
            num_reg    <= num_next;
            sd_reg     <= sd_next;
            neg3_reg   <= neg2_reg;
            cross3_reg <= cross2_reg;
            numa_reg   <= numa_next;
            sd4_reg    <= sd_reg;
            cross4_reg <= cross3_reg;
            flag_reg   <= flag_next;
            flag6_reg  <= flag_reg;
        end
    end

    assign hit = flag6_reg;

endmodule

// ----- rtl/triangle_box_overlap_test_top.sv -----
// Triangle versus axis-aligned box overlap test, one request per cycle.
// A request on the s_ channel carries three vertices, the box corner and the
// box extents; the m_ channel returns one flag per request, in order.
// The flag is set when a vertex is in the closed box, a box corner passes the
// barycentric test with a tolerance of one millionth, or an edge strictly
// crosses a box side within its open span.
// m_tvalid rises once the request has passed through nine register
// stages: an input register, a coordinate stage, six stages of product and
// compare lanes, and the output register. A new request is taken every cycle.
// The whole pipeline holds when m_tvalid is high and m_tready is low;
// s_tready is low for exactly those cycles, so nothing is lost or repeated.
// Reset (rst_n low, asynchronous) clears all valid bits; the data registers
// are not reset.
// depends on tbo_pkg, tbo_corner_lane and tbo_edge_lane
module triangle_box_overlap_test_top
    import tbo_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    // vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x, vert_c_y,
    // box_min_x, box_min_y (32 each), box_width, box_height (31 each), 2 pad
    input  logic [IN_W-1:0]   s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // overlaps (1), 7 pad
    output logic [OUT_W-1:0]  m_tdata
);

    localparam int NSTG = 9;
    localparam int NDLY = 6;

    logic            en;
    logic [NSTG-1:0] vld_reg, vld_next;

    logic signed [CB-1:0] ax1_reg, ay1_reg, bx1_reg, by1_reg, cx1_reg, cy1_reg;
    logic signed [CB-1:0] x01_reg, y01_reg;
    logic [CB-2:0]        w1_reg, h1_reg;

    coord_t ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;
    coord_t x0_reg, y0_reg, x1_reg, y1_reg, w_reg, h_reg;
    coord_t x1_next, y1_next;

    logic            inbox_next;
    logic [NDLY-1:0] inbox_reg;
    logic [3:0]      corner_hit;
    logic [11:0]     edge_hit;
    logic            ovl_reg, ovl_next;

    assign en       = !vld_reg[NSTG-1] || m_tready;
    assign s_tready = en;

    always_comb
    begin
        vld_next = {vld_reg[NSTG-2:0], s_tvalid};
        x1_next  = XW'(x01_reg) + XW'(w1_reg);
        y1_next  = XW'(y01_reg) + XW'(h1_reg);
        inbox_next =
            ((ax_reg >= x0_reg) && (ay_reg >= y0_reg) && (ax_reg <= x1_reg) && (ay_reg <= y1_reg)) ||
            ((bx_reg >= x0_reg) && (by_reg >= y0_reg) && (bx_reg <= x1_reg) && (by_reg <= y1_reg)) ||
            ((cx_reg >= x0_reg) && (cy_reg >= y0_reg) && (cx_reg <= x1_reg) && (cy_reg <= y1_reg));
        ovl_next = inbox_reg[NDLY-1] || (|corner_hit) || (|edge_hit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax1_reg   <= s_tdata[OFS_AX +: CB];
            ay1_reg   <= s_tdata[OFS_AY +: CB];
            bx1_reg   <= s_tdata[OFS_BX +: CB];
            by1_reg   <= s_tdata[OFS_BY +: CB];
            cx1_reg   <= s_tdata[OFS_CX +: CB];
            cy1_reg   <= s_tdata[OFS_CY +: CB];
            x01_reg   <= s_tdata[OFS_X0 +: CB];
            y01_reg   <= s_tdata[OFS_Y0 +: CB];
            w1_reg    <= s_tdata[OFS_W +: CB-1];
            h1_reg    <= s_tdata[OFS_H +: CB-1];
            ax_reg    <= XW'(ax1_reg);
            ay_reg    <= XW'(ay1_reg);
            bx_reg    <= XW'(bx1_reg);
            by_reg    <= XW'(by1_reg);
            cx_reg    <= XW'(cx1_reg);
            cy_reg    <= XW'(cy1_reg);
            x0_reg    <= XW'(x01_reg);
            y0_reg    <= XW'(y01_reg);
            w_reg     <= XW'(w1_reg);
            h_reg     <= XW'(h1_reg);
            x1_reg    <= x1_next;
            y1_reg    <= y1_next;
            inbox_reg <= {inbox_reg[NDLY-2:0], inbox_next};
            ovl_reg   <= ovl_next;
        end
    end

    // box corners: lower-left, lower-right, upper-right, upper-left
    tbo_corner_lane u_c0 (.clk(clk), .en(en), .ax(ax_reg), .ay(ay_reg), .bx(bx_reg),
        .by(by_reg), .cx(cx_reg), .cy(cy_reg), .px(x0_reg), .py(y0_reg),
        .corner_in(corner_hit[0]));
    tbo_corner_lane u_c1 (.clk(clk), .en(en), .ax(ax_reg), .ay(ay_reg), .bx(bx_reg),
        .by(by_reg), .cx(cx_reg), .cy(cy_reg), .px(x1_reg), .py(y0_reg),
        .corner_in(corner_hit[1]));
    tbo_corner_lane u_c2 (.clk(clk), .en(en), .ax(ax_reg), .ay(ay_reg), .bx(bx_reg),
        .by(by_reg), .cx(cx_reg), .cy(cy_reg), .px(x1_reg), .py(y1_reg),
        .corner_in(corner_hit[2]));
    tbo_corner_lane u_c3 (.clk(clk), .en(en), .ax(ax_reg), .ay(ay_reg), .bx(bx_reg),
        .by(by_reg), .cx(cx_reg), .cy(cy_reg), .px(x0_reg), .py(y1_reg),
        .corner_in(corner_hit[3]));

    // edge ab against top, bottom, right, left
    tbo_edge_lane u_e0 (.clk(clk), .en(en), .pa(ay_reg), .qa(ax_reg), .pb(by_reg),
        .qb(bx_reg), .line(y1_reg), .lo(x0_reg), .span(w_reg), .hit(edge_hit[0]));
    tbo_edge_lane u_e1 (.clk(clk), .en(en), .pa(ay_reg), .qa(ax_reg), .pb(by_reg),
        .qb(bx_reg), .line(y0_reg), .lo(x0_reg), .span(w_reg), .hit(edge_hit[1]));
    tbo_edge_lane u_e2 (.clk(clk), .en(en), .pa(ax_reg), .qa(ay_reg), .pb(bx_reg),
        .qb(by_reg), .line(x1_reg), .lo(y0_reg), .span(h_reg), .hit(edge_hit[2]));
    tbo_edge_lane u_e3 (.clk(clk), .en(en), .pa(ax_reg), .qa(ay_reg), .pb(bx_reg),
        .qb(by_reg), .line(x0_reg), .lo(y0_reg), .span(h_reg), .hit(edge_hit[3]));
    // edge ac
    tbo_edge_lane u_e4 (.clk(clk), .en(en), .pa(ay_reg), .qa(ax_reg), .pb(cy_reg),
        .qb(cx_reg), .line(y1_reg), .lo(x0_reg), .span(w_reg), .hit(edge_hit[4]));
    tbo_edge_lane u_e5 (.clk(clk), .en(en), .pa(ay_reg), .qa(ax_reg), .pb(cy_reg),
        .qb(cx_reg), .line(y0_reg), .lo(x0_reg), .span(w_reg), .hit(edge_hit[5]));
    tbo_edge_lane u_e6 (.clk(clk), .en(en), .pa(ax_reg), .qa(ay_reg), .pb(cx_reg),
        .qb(cy_reg), .line(x1_reg), .lo(y0_reg), .span(h_reg), .hit(edge_hit[6]));
    tbo_edge_lane u_e7 (.clk(clk), .en(en), .pa(ax_reg), .qa(ay_reg), .pb(cx_reg),
        .qb(cy_reg), .line(x0_reg), .lo(y0_reg), .span(h_reg), .hit(edge_hit[7]));
    // edge bc
    tbo_edge_lane u_e8 (.clk(clk), .en(en), .pa(by_reg), .qa(bx_reg), .pb(cy_reg),
        .qb(cx_reg), .line(y1_reg), .lo(x0_reg), .span(w_reg), .hit(edge_hit[8]));
    tbo_edge_lane u_e9 (.clk(clk), .en(en), .pa(by_reg), .qa(bx_reg), .pb(cy_reg),
        .qb(cx_reg), .line(y0_reg), .lo(x0_reg), .span(w_reg), .hit(edge_hit[9]));
    tbo_edge_lane u_e10 (.clk(clk), .en(en), .pa(bx_reg), .qa(by_reg), .pb(cx_reg),
        .qb(cy_reg), .line(x1_reg), .lo(y0_reg), .span(h_reg), .hit(edge_hit[10]));
    tbo_edge_lane u_e11 (.clk(clk), .en(en), .pa(bx_reg), .qa(by_reg), .pb(cx_reg),
        .qb(cy_reg), .line(x0_reg), .lo(y0_reg), .span(h_reg), .hit(edge_hit[11]));

    assign m_tvalid = vld_reg[NSTG-1];
    assign m_tdata  = {{(OUT_W-1){1'b0}}, ovl_reg};

endmodule

// ----- rtl/tbo_checker.sv -----
// port-level checks for the triangle/box overlap test, bound to the top level
// depends on tbo_pkg and triangle_box_overlap_test_top
module tbo_checker
    import tbo_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // input side stalls exactly when the output is blocked
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow output stall");

    // only the flag bit carries data
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_W-1:1] == '0)
        else $error("padding bits set");

    // a reset cycle leaves no result valid
    a_rst: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind triangle_box_overlap_test_top tbo_checker u_tbo_checker (
    .clk(clk),
    .rst_n(rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
);
